>>> sv/vnf_pkg.sv
// shared types, constants and hash helpers for the fractal value noise unit
`default_nettype none
package vnf_pkg;

   localparam int MAX_OCTAVES = 8;
   localparam int FRAC_BITS   = 16;
   localparam int FR_DOWN     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int FR_UP       = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int VAL_W       = 24;
   localparam int SUM_W       = VAL_W + MAX_OCTAVES;
   localparam int CELL_STAGES = 9;
   localparam int DIV_STAGES  = SUM_W;
   localparam int LATENCY     = CELL_STAGES * MAX_OCTAVES + DIV_STAGES;

   localparam logic [31:0] MIX_K1  = 32'h7feb352d;
   localparam logic [31:0] MIX_K2  = 32'h846ca68b;
   localparam logic [31:0] GOLDEN  = 32'h9e3779b9;
   localparam logic [31:0] Z_MULT  = 32'h85ebca6b;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES = 2'd1;
   localparam logic [3:0] OCTAVES_RESET = 4'd4;

   typedef struct packed {
      logic             valid;
      logic [31:0]      x;
      logic [31:0]      z;
      logic [SUM_W-1:0] w;
   } item_type;

   // first, second and last step of the avalanche hash
   function automatic logic [31:0] mix_a(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v >> 16);
      return t * MIX_K1;
   endfunction

   function automatic logic [31:0] mix_b(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v >> 15);
      return t * MIX_K2;
   endfunction

   function automatic logic [31:0] mix_c(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

endpackage
`default_nettype wire

>>> sv/vnf_octave_cell.sv
// one octave of the noise sum: split, corner hash, fade, bilinear blend, weighted add
`default_nettype none
module vnf_octave_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [vnf_pkg::OCT_W-1:0] octave_index,
   input  wire logic [31:0]              seed_value,
   input  wire logic [vnf_pkg::OCT_W-1:0] octave_count,
   input  wire vnf_pkg::item_type        item_in,
   output vnf_pkg::item_type             item_out
);
   import vnf_pkg::*;

   item_type pipe_ff [0:7];
   item_type out_ff;

   logic [31:0] cx1_ff [2];
   logic [31:0] cz1_ff [2];
   logic [15:0] tx1_ff, tz1_ff;
   logic [31:0] hx2_ff [2];
   logic [31:0] hz2_ff [2];
   logic [15:0] tx2_ff, tz2_ff;
   logic [31:0] ttx2_ff, ttz2_ff;
   logic [31:0] mx3_ff [2];
   logic [31:0] mz3_ff [2];
   logic [31:0] t3x3_ff, t3z3_ff;
   logic [36:0] px3_ff, pz3_ff;
   logic [31:0] mx4_ff [2];
   logic [31:0] mz4_ff [2];
   logic [16:0] fx4_ff, fz4_ff;
   logic [31:0] h5_ff [4];
   logic [16:0] fx5_ff, fz5_ff;
   logic [31:0] h6_ff [4];
   logic [16:0] fx6_ff, fz6_ff;
   logic [23:0] a7_ff [2];
   logic        neg7_ff [2];
   logic [23:0] p7_ff [2];
   logic [16:0] fz7_ff;
   logic [23:0] a8_ff;
   logic        neg8_ff;
   logic [23:0] p8_ff;

   logic [31:0] cx_in, cz_in, sd;
   logic [15:0] tx_in, tz_in;
   logic [63:0] scx, scz;
   logic [FRAC_BITS-1:0] frx, frz;
   logic [36:0] fxp, fzp;
   logic [31:0] h7 [4];
   logic [23:0] c7 [4];
   logic [23:0] l8 [2];
   logic [23:0] v9;
   logic [OCT_W-1:0] shamt;
   logic        active;

   // split into integer cell and 16-bit fraction
   always_comb begin
      scx   = {{32{item_in.x[31]}}, item_in.x} << octave_index;
      scz   = {{32{item_in.z[31]}}, item_in.z} << octave_index;
      cx_in = scx[FRAC_BITS +: 32];
      cz_in = scz[FRAC_BITS +: 32];
      frx   = scx[FRAC_BITS-1:0];
      frz   = scz[FRAC_BITS-1:0];
      tx_in = 16'((32'(frx) >> FR_DOWN) << FR_UP);
      tz_in = 16'((32'(frz) >> FR_DOWN) << FR_UP);
   end

   assign sd  = seed_value + 32'(octave_index) * GOLDEN;
   assign fxp = 37'(t3x3_ff[31:16]) * 37'(px3_ff[36:16]);
   assign fzp = 37'(t3z3_ff[31:16]) * 37'(pz3_ff[36:16]);

   // corner values for the first lerp
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         h7[k] = mix_c(h6_ff[k]);
         c7[k] = h7[k][31:8];
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         l8[k] = neg7_ff[k] ? a7_ff[k] - p7_ff[k] : a7_ff[k] + p7_ff[k];
      end
      v9     = neg8_ff ? a8_ff - p8_ff : a8_ff + p8_ff;
      active = octave_index < octave_count;
      shamt  = octave_count - octave_index - OCT_W'(1);
   end

   always_ff @(posedge clock) begin
      // stage 1
      cx1_ff[0] <= cx_in;
      cx1_ff[1] <= cx_in + 32'd1;
      cz1_ff[0] <= cz_in;
      cz1_ff[1] <= cz_in + 32'd1;
      tx1_ff    <= tx_in;
      tz1_ff    <= tz_in;
      // stage 2
      for (int k = 0; k < 2; k++) begin
         hx2_ff[k] <= cx1_ff[k] * GOLDEN;
         hz2_ff[k] <= cz1_ff[k] * Z_MULT;
      end
      tx2_ff  <= tx1_ff;
      tz2_ff  <= tz1_ff;
      ttx2_ff <= 32'(tx1_ff) * 32'(tx1_ff);
      ttz2_ff <= 32'(tz1_ff) * 32'(tz1_ff);
      // stage 3
      for (int k = 0; k < 2; k++) begin
         mx3_ff[k] <= mix_a(hx2_ff[k]);
         mz3_ff[k] <= mix_a(hz2_ff[k]);
      end
      t3x3_ff <= 32'(ttx2_ff[31:16]) * 32'(tx2_ff);
      t3z3_ff <= 32'(ttz2_ff[31:16]) * 32'(tz2_ff);
      px3_ff  <= (37'd10 << 32) + 37'd6 * 37'(ttx2_ff) - 37'd15 * (37'(tx2_ff) << 16);
      pz3_ff  <= (37'd10 << 32) + 37'd6 * 37'(ttz2_ff) - 37'd15 * (37'(tz2_ff) << 16);
      // stage 4
      for (int k = 0; k < 2; k++) begin
         mx4_ff[k] <= mix_b(mx3_ff[k]);
         mz4_ff[k] <= mix_b(mz3_ff[k]);
      end
      fx4_ff <= fxp[32:16];
      fz4_ff <= fzp[32:16];
      // stage 5: corner order 00, 10, 01, 11
      for (int k = 0; k < 4; k++) begin
         h5_ff[k] <= mix_a(sd ^ mix_c(mx4_ff[k % 2]) ^ mix_c(mz4_ff[k / 2]));
      end
      fx5_ff <= fx4_ff;
      fz5_ff <= fz4_ff;
      // stage 6
      for (int k = 0; k < 4; k++) begin
         h6_ff[k] <= mix_b(h5_ff[k]);
      end
      fx6_ff <= fx5_ff;
      fz6_ff <= fz5_ff;
      // stage 7: lerp along x
      for (int k = 0; k < 2; k++) begin
         a7_ff[k]   <= c7[2*k];
         neg7_ff[k] <= c7[2*k+1] < c7[2*k];
         p7_ff[k]   <= 24'(((41'(c7[2*k+1] < c7[2*k] ? c7[2*k] - c7[2*k+1]
                                                      : c7[2*k+1] - c7[2*k]))
                            * 41'(fx6_ff)) >> 16);
      end
      fz7_ff <= fz6_ff;
      // stage 8: lerp along z
      a8_ff   <= l8[0];
      neg8_ff <= l8[1] < l8[0];
      p8_ff   <= 24'(((41'(l8[1] < l8[0] ? l8[0] - l8[1] : l8[1] - l8[0]))
                      * 41'(fz7_ff)) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else begin
         pipe_ff[0] <= item_in;
         for (int k = 1; k < 8; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
         out_ff.valid <= pipe_ff[7].valid;
         out_ff.x     <= pipe_ff[7].x;
         out_ff.z     <= pipe_ff[7].z;
         out_ff.w     <= active ? pipe_ff[7].w + (SUM_W'(v9) << shamt) : pipe_ff[7].w;
      end
   end

   assign item_out = out_ff;

endmodule
`default_nettype wire

>>> sv/vnf_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vnf_div_pipe (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [vnf_pkg::SUM_W-1:0]      in_num,
   input  wire logic [vnf_pkg::MAX_OCTAVES-1:0] divisor,
   output logic                                out_valid,
   output logic [vnf_pkg::SUM_W-1:0]           out_quo
);
   import vnf_pkg::*;

   localparam int R_W = MAX_OCTAVES;

   logic             valid_ff [0:DIV_STAGES-1];
   logic [R_W-1:0]   rem_ff   [0:DIV_STAGES-1];
   logic [SUM_W-1:0] num_ff   [0:DIV_STAGES-1];
   logic [SUM_W-1:0] quo_ff   [0:DIV_STAGES-1];

   logic [R_W-1:0]   rem_src [0:DIV_STAGES-1];
   logic [SUM_W-1:0] num_src [0:DIV_STAGES-1];
   logic [SUM_W-1:0] quo_src [0:DIV_STAGES-1];
   logic [R_W:0]     trial   [0:DIV_STAGES-1];
   logic             ge      [0:DIV_STAGES-1];

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_src[k] = (k == 0) ? '0     : rem_ff[(k == 0) ? 0 : k-1];
         num_src[k] = (k == 0) ? in_num : num_ff[(k == 0) ? 0 : k-1];
         quo_src[k] = (k == 0) ? '0     : quo_ff[(k == 0) ? 0 : k-1];
         trial[k]   = {rem_src[k], num_src[k][SUM_W-1]};
         ge[k]      = trial[k] >= {1'b0, divisor};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_ff[k] <= ge[k] ? R_W'(trial[k] - {1'b0, divisor}) : trial[k][R_W-1:0];
         num_ff[k] <= num_src[k] << 1;
         quo_ff[k] <= {quo_src[k][SUM_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> sv/value_noise_fbm_2d_unit.sv
// top level of the 2d fractal value noise unit
//
// usage
//  - request: drive req_x_coord / req_z_coord (signed q16.16) and pulse start;
//    a transfer happens at a rising edge with start high and busy low. busy
//    stays low, so a new point can enter on every cycle
//  - response: rsp_valid is high for one cycle with rsp_noise_value (unsigned
//    q0.24); the receiver cannot stall, so results must be taken as they come
//  - csr: csr_valid / csr_ready write channel, csr_index 0 = seed, 1 = octave
//    count; csr_ready is always high. write only while no request is in flight
//  - path: a request passes through 8 octave cells and then 32 divider
//    stages on its way to the response, for any octave count
//  - throughput: one point per cycle, set by the fully pipelined cell chain
//    (one cell per octave) and the one-bit-per-stage divider
//  - reset: synchronous, clears all pipeline valids, seed to 0, octaves to 4
`default_nettype none
module value_noise_fbm_2d_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [31:0]              req_x_coord,
   input  wire logic signed [31:0]              req_z_coord,
   output logic                                 rsp_valid,
   output logic [23:0]                          rsp_noise_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [vnf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                     csr_wdata
);
   import vnf_pkg::*;

   logic [31:0]      seed_ff;
   logic [3:0]       octaves_ff;
   logic [OCT_W-1:0] n_eff;
   logic [MAX_OCTAVES-1:0] divisor;
   item_type         chain [0:MAX_OCTAVES];
   logic             accepted;
   logic             div_valid;
   logic [SUM_W-1:0] div_quo;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accepted  = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         octaves_ff <= OCTAVES_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEED:    seed_ff    <= csr_wdata;
            CSR_OCTAVES: octaves_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // octave count saturates at the number of cells
   always_comb begin
      n_eff   = (32'(octaves_ff) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES) : OCT_W'(octaves_ff);
      // normalizer is the sum of the weights, 2^n - 1
      divisor = MAX_OCTAVES'((32'd1 << n_eff) - 32'd1);
   end

   always_comb begin
      chain[0].valid = accepted;
      chain[0].x     = req_x_coord;
      chain[0].z     = req_z_coord;
      chain[0].w     = '0;
   end

   // one cell per octave, each adds its weighted value to the running sum
   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
      vnf_octave_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .octave_index (OCT_W'(o)),
         .seed_value   (seed_ff),
         .octave_count (n_eff),
         .item_in      (chain[o]),
         .item_out     (chain[o+1])
      );
   end

   vnf_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain[MAX_OCTAVES].valid),
      .in_num    (chain[MAX_OCTAVES].w),
      .divisor   (divisor),
      .out_valid (div_valid),
      .out_quo   (div_quo)
   );

   // zero octaves gives zero (the divider would see a zero divisor)
   assign rsp_valid       = div_valid;
   assign rsp_noise_value = (n_eff == '0) ? '0 : div_quo[VAL_W-1:0];

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accepted, LATENCY))
      else $error("response without matching request");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##LATENCY rsp_valid)
      else $error("request transfer lost in pipeline");

endmodule
`default_nettype wire
